[src/tli_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_pkg: shared types and helpers for the table interpolator
// Opcodes, state types, the floating-point unit request and binary64
// classification and compare functions.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int FP_EW = 14;

  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_E_FROM_P = 2'd1;
  localparam logic [1:0] OP_P_FROM_E = 2'd2;

  localparam logic [63:0] DEFAULT_NAN  = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] ZERO_DIV_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;

  typedef enum logic [1:0] {FOP_ADD, FOP_SUB, FOP_MUL, FOP_DIV} fop_t;

  typedef struct packed {
    logic start;
    fop_t op;
  } fpu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_RANGE, ST_RDL, ST_RDR, ST_LOADR, ST_FPGO, ST_FPWAIT, ST_FINISH
  } top_state_t;

  typedef enum logic [2:0] {
    STEP_DQ, STEP_DV, STEP_DK, STEP_MUL, STEP_DIV, STEP_ADD
  } step_t;

  typedef enum logic [3:0] {
    F_IDLE, F_PREP, F_ALIGN, F_ADDS, F_MUL, F_DNORM, F_DIV, F_NORM, F_ROUND, F_FIN
  } fpu_state_t;

  function automatic logic fp_is_nan(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  function automatic logic fp_is_inf(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] == 52'd0);
  endfunction

  function automatic logic fp_is_zero(input logic [63:0] x);
    return x[62:0] == 63'd0;
  endfunction

  function automatic logic [63:0] fp_quiet(input logic [63:0] x);
    return x | QUIET_BIT;
  endfunction

  // IEEE less-than: false whenever a NaN takes part, and -0 equals +0.
  function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
    logic r;
    if (fp_is_nan(a) || fp_is_nan(b)) begin
      r = 1'b0;
    end else if (fp_is_zero(a) && fp_is_zero(b)) begin
      r = 1'b0;
    end else if (a[63] != b[63]) begin
      r = a[63];
    end else if (!a[63]) begin
      r = a[62:0] < b[62:0];
    end else begin
      r = a[62:0] > b[62:0];
    end
    return r;
  endfunction

  function automatic logic [52:0] fp_mant(input logic [63:0] x);
    return {x[62:52] != 11'd0, x[51:0]};
  endfunction

  function automatic logic signed [FP_EW-1:0] fp_exp(input logic [63:0] x);
    logic signed [FP_EW-1:0] e;
    if (x[62:52] == 11'd0) begin
      e = FP_EW'(1);
    end else begin
      e = FP_EW'({1'b0, x[62:52]});
    end
    return e;
  endfunction

endpackage

[src/tli_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module tli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/tli_fpu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_fpu: iterative binary64 add, subtract, multiply and divide
// One shared mantissa datapath: shift-add multiply, restoring divide and a
// bit-at-a-time normalizer ahead of round-to-nearest-even.
// ----------------------------------------------------------------------------
module tli_fpu (
  input  logic              clk,
  input  logic              rst,
  input  tli_pkg::fpu_req_t req,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output logic              done,
  output logic [63:0]       result
);
  import tli_pkg::*;

  localparam int MW = 107;
  localparam int EW = FP_EW;

  fpu_state_t state, state_next;
  fop_t op;
  logic [63:0] ra, rb;
  logic rs, sticky, eff_sub;
  logic signed [EW-1:0] ea, eb, ex;
  logic [52:0] ma, mb;
  logic [MW-1:0] mw, mbs;
  logic [53:0] rem;
  logic [55:0] qd;
  logic [6:0] cnt;

  logic [63:0] bx, big_w, small_w, spec_res;
  logic na, nb, ia, ib, za, zb, sa, sb, swap, spec_hit;
  logic signed [EW-1:0] dsh;
  logic [MW-1:0] xs, al, big_m, sum;
  logic ast;
  logic ge;
  logic [53:0] rem_sub, rem_next;
  logic [55:0] qd_next;
  logic shr, shl, nzero, ndone;
  logic [52:0] rmant, rmant_r;
  logic rguard, rsticky;
  logic [53:0] rsum;
  logic signed [EW-1:0] rex;
  logic [63:0] rpack;

  // Operand classification and the special-value results.
  always_comb begin
    bx = rb;
    if (op == FOP_SUB && !fp_is_nan(rb)) begin
      bx = {~rb[63], rb[62:0]};
    end
    na = fp_is_nan(ra);
    nb = fp_is_nan(bx);
    ia = fp_is_inf(ra);
    ib = fp_is_inf(bx);
    za = fp_is_zero(ra);
    zb = fp_is_zero(bx);
    sa = ra[63];
    sb = bx[63];
    swap = bx[62:0] > ra[62:0];
    big_w = swap ? bx : ra;
    small_w = swap ? ra : bx;
    spec_hit = 1'b1;
    spec_res = '0;
    case (op)
      FOP_ADD, FOP_SUB: begin
        if (na) spec_res = fp_quiet(ra);
        else if (nb) spec_res = fp_quiet(bx);
        else if (ia && ib && (sa != sb)) spec_res = DEFAULT_NAN;
        else if (ia) spec_res = ra;
        else if (ib) spec_res = bx;
        else if (za && zb) spec_res = {sa & sb, 63'd0};
        else if (za) spec_res = bx;
        else if (zb) spec_res = ra;
        else spec_hit = 1'b0;
      end
      FOP_MUL: begin
        if (na) spec_res = fp_quiet(ra);
        else if (nb) spec_res = fp_quiet(bx);
        else if ((ia && zb) || (za && ib)) spec_res = DEFAULT_NAN;
        else if (ia || ib) spec_res = {sa ^ sb, 11'h7FF, 52'd0};
        else if (za || zb) spec_res = {sa ^ sb, 63'd0};
        else spec_hit = 1'b0;
      end
      FOP_DIV: begin
        if (na) spec_res = fp_quiet(ra);
        else if (nb) spec_res = fp_quiet(bx);
        else if ((ia && ib) || (za && zb)) spec_res = DEFAULT_NAN;
        else if (ia || zb) spec_res = {sa ^ sb, 11'h7FF, 52'd0};
        else if (ib || za) spec_res = {sa ^ sb, 63'd0};
        else spec_hit = 1'b0;
      end
      default: spec_hit = 1'b0;
    endcase
  end

  // Alignment of the smaller addend, with everything shifted out kept as sticky.
  always_comb begin
    dsh = ea - eb;
    xs = {1'b0, mb, 53'd0};
    if (dsh >= EW'(MW)) begin
      al = '0;
      ast = 1'b1;
    end else begin
      al = xs >> dsh[6:0];
      ast = ((al << dsh[6:0]) != xs);
    end
    big_m = {1'b0, ma, 53'd0};
    if (eff_sub) begin
      sum = big_m - mbs - MW'(sticky);
    end else begin
      sum = big_m + mbs;
    end
  end

  always_comb begin
    ge = rem >= {1'b0, mb};
    rem_sub = ge ? (rem - {1'b0, mb}) : rem;
    rem_next = {rem_sub[52:0], 1'b0};
    qd_next = {qd[54:0], ge};
  end

  // The leading one belongs at bit 105; below exponent 1 the value goes subnormal.
  always_comb begin
    shr = 1'b0;
    shl = 1'b0;
    nzero = 1'b0;
    ndone = 1'b0;
    if (mw[106]) shr = 1'b1;
    else if (mw == '0) nzero = 1'b1;
    else if (ex < EW'(1)) shr = 1'b1;
    else if (!mw[105] && (ex > EW'(1))) shl = 1'b1;
    else ndone = 1'b1;
  end

  always_comb begin
    rmant = mw[105:53];
    rguard = mw[52];
    rsticky = (|mw[51:0]) | sticky;
    rsum = {1'b0, rmant} + 54'(rguard & (rsticky | rmant[0]));
    rex = ex;
    if (rsum[53]) begin
      rmant_r = rsum[53:1];
      rex = ex + EW'(1);
    end else begin
      rmant_r = rsum[52:0];
    end
    if (rex >= EW'(2047)) rpack = {rs, 11'h7FF, 52'd0};
    else if (rmant_r[52]) rpack = {rs, rex[10:0], rmant_r[51:0]};
    else rpack = {rs, 11'd0, rmant_r[51:0]};
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (req.start) state_next = F_PREP;
      F_PREP: begin
        if (spec_hit) state_next = F_FIN;
        else if (op == FOP_MUL) state_next = F_MUL;
        else if (op == FOP_DIV) state_next = F_DNORM;
        else state_next = F_ALIGN;
      end
      F_ALIGN: state_next = F_ADDS;
      F_ADDS:  state_next = F_NORM;
      F_MUL:   if (cnt == 7'd52) state_next = F_NORM;
      F_DNORM: if (ma[52] && mb[52]) state_next = F_DIV;
      F_DIV:   if (cnt == 7'd55) state_next = F_NORM;
      F_NORM:  if (ndone || nzero) state_next = F_ROUND;
      F_ROUND: state_next = F_FIN;
      F_FIN:   state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    done = (state == F_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (req.start) begin
          op <= req.op;
          ra <= a;
          rb <= b;
        end
      end
      F_PREP: begin
        sticky <= 1'b0;
        cnt <= '0;
        mw <= '0;
        rs <= sa ^ sb;
        if (spec_hit) begin
          result <= spec_res;
        end
        if (op == FOP_ADD || op == FOP_SUB) begin
          ma <= fp_mant(big_w);
          ea <= fp_exp(big_w);
          mb <= fp_mant(small_w);
          eb <= fp_exp(small_w);
          rs <= big_w[63];
          eff_sub <= sa ^ sb;
        end else begin
          ma <= fp_mant(ra);
          ea <= fp_exp(ra);
          mb <= fp_mant(bx);
          eb <= fp_exp(bx);
          mbs <= MW'(fp_mant(bx));
          ex <= fp_exp(ra) + fp_exp(bx) - EW'(1022);
        end
      end
      F_ALIGN: begin
        mbs <= al;
        sticky <= ast;
      end
      F_ADDS: begin
        mw <= sum;
        ex <= ea;
        // An exact cancellation rounds to +0.
        if (eff_sub && (sum == '0) && !sticky) begin
          rs <= 1'b0;
        end
      end
      F_MUL: begin
        if (ma[0]) begin
          mw <= mw + mbs;
        end
        ma <= ma >> 1;
        mbs <= mbs << 1;
        cnt <= cnt + 7'd1;
      end
      F_DNORM: begin
        if (!ma[52]) begin
          ma <= ma << 1;
          ea <= ea - EW'(1);
        end
        if (!mb[52]) begin
          mb <= mb << 1;
          eb <= eb - EW'(1);
        end
        rem <= {1'b0, ma};
        qd <= '0;
        cnt <= '0;
        ex <= ea - eb + EW'(1023);
      end
      F_DIV: begin
        rem <= rem_next;
        qd <= qd_next;
        cnt <= cnt + 7'd1;
        if (cnt == 7'd55) begin
          mw <= {1'b0, qd_next, 50'd0};
          sticky <= (rem_next != '0);
        end
      end
      F_NORM: begin
        if (shr) begin
          mw <= mw >> 1;
          sticky <= sticky | mw[0];
          ex <= ex + EW'(1);
        end else if (shl) begin
          mw <= mw << 1;
          ex <= ex - EW'(1);
        end else if (nzero) begin
          ex <= EW'(1);
        end
      end
      F_ROUND: result <= rpack;
      default: ;
    endcase
  end

endmodule

[src/table_linear_interpolator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_linear_interpolator: binary64 piecewise linear table lookup
// Holds (pressure, energy) pairs and interpolates one column from the other.
// ----------------------------------------------------------------------------
// Usage:
// An input beat carries an opcode. A write stores one table entry; the two
// lookup opcodes scan the first entries_used keys for their span and for the
// first key not below the query, then interpolate between that entry and the
// one before it. Every input beat gives exactly one output beat.
// The configuration channel is always ready and sets entries_used; write it
// only while no beat is in flight.
// A write or an unused opcode goes from acceptance to ST_FINISH and enters the
// output register once the output is free. A lookup scans n entries, where n
// is the clamped entry count: one entry per cycle on the RAM read port, then
// up to six operations on the shared iterative FP unit (the divide is skipped
// on a zero key span, and an out-of-range query skips them all). Subnormal
// operands or heavy cancellation lengthen the normalizing steps.
// One beat is worked on at a time; in_stall is high from acceptance until the
// result is moved into the output register. A stalled output holds the result
// and the block may take the next beat meanwhile. Reset empties the output and
// sets entries_used to 2; the table contents stay undefined until written.
// ----------------------------------------------------------------------------
module table_linear_interpolator #(
  parameter int MAX_ENTRIES = tli_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [5:0]  entry_index,
  input  logic [63:0] pressure_word,
  input  logic [63:0] energy_word,
  input  logic [63:0] query_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_word,
  output logic        status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  entries_used
);
  import tli_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NW = ($clog2(MAX_ENTRIES + 1) > 7) ? $clog2(MAX_ENTRIES + 1) : 7;

  top_state_t state, state_next;
  step_t step, step_after;
  logic [6:0] eu;
  logic [NW-1:0] n, ia, ic, pos, n_clamp, eu_w, pos_clamp;
  logic have, found, key_p;
  logic [63:0] q, lo, hi, kl, kr, vl, vr, t1, t2, t3, res_word;
  logic res_stat;

  logic in_accept, issue, oor, skip_div, out_load, wr_en;
  logic [AW-1:0] raddr;
  logic [63:0] rdata_p, rdata_e, key_rd, val_rd, fa, fb, qspec, fres;
  fpu_req_t freq;
  logic fdone;

  tli_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_pressure_ram (
    .clk(clk), .we(wr_en), .waddr(AW'(entry_index)), .wdata(pressure_word),
    .raddr(raddr), .rdata(rdata_p)
  );

  tli_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_energy_ram (
    .clk(clk), .we(wr_en), .waddr(AW'(entry_index)), .wdata(energy_word),
    .raddr(raddr), .rdata(rdata_e)
  );

  tli_fpu u_fpu (
    .clk(clk), .rst(rst), .req(freq), .a(fa), .b(fb), .done(fdone), .result(fres)
  );

  always_comb begin
    in_accept = in_valid && !in_stall;
    wr_en = in_accept && (opcode == OP_WRITE) && (32'(entry_index) < 32'(MAX_ENTRIES));
    eu_w = NW'(eu);
    if (eu_w < NW'(2)) n_clamp = NW'(2);
    else if (eu_w > NW'(MAX_ENTRIES)) n_clamp = NW'(MAX_ENTRIES);
    else n_clamp = eu_w;
    issue = ia < n;
    key_rd = key_p ? rdata_p : rdata_e;
    val_rd = key_p ? rdata_e : rdata_p;
    oor = fp_lt(q, lo) || fp_lt(hi, q);
    // No entry stops the search: take the last segment; a hit at entry 0 takes the first.
    pos_clamp = found ? pos : (n - NW'(1));
    if (pos_clamp == '0) pos_clamp = NW'(1);
    skip_div = (step == STEP_DIV) && fp_is_zero(t3);
    if (fp_is_nan(t1)) qspec = t1;
    else if (fp_is_zero(t1)) qspec = ZERO_DIV_NAN;
    else qspec = {t1[63] ^ t3[63], 11'h7FF, 52'd0};
    out_load = (state == ST_FINISH) && (!out_valid || !out_stall);
    case (step)
      STEP_DQ:  step_after = STEP_DV;
      STEP_DV:  step_after = STEP_DK;
      STEP_DK:  step_after = STEP_MUL;
      STEP_MUL: step_after = STEP_DIV;
      STEP_DIV: step_after = STEP_ADD;
      default:  step_after = STEP_ADD;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (opcode == OP_E_FROM_P || opcode == OP_P_FROM_E) state_next = ST_SCAN;
          else state_next = ST_FINISH;
        end
      end
      ST_SCAN:   if (have && (ic == n - NW'(1))) state_next = ST_RANGE;
      ST_RANGE:  state_next = oor ? ST_FINISH : ST_RDL;
      ST_RDL:    state_next = ST_RDR;
      ST_RDR:    state_next = ST_LOADR;
      ST_LOADR:  state_next = ST_FPGO;
      ST_FPGO:   if (!skip_div) state_next = ST_FPWAIT;
      ST_FPWAIT: begin
        if (fdone) state_next = (step == STEP_ADD) ? ST_FINISH : ST_FPGO;
      end
      ST_FINISH: if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    cfg_ready = 1'b1;
    case (state)
      ST_RDL:  raddr = AW'(pos - NW'(1));
      ST_RDR:  raddr = AW'(pos);
      default: raddr = AW'(ia);
    endcase
    freq.start = (state == ST_FPGO) && !skip_div;
    freq.op = FOP_SUB;
    fa = t1;
    fb = vl;
    case (step)
      STEP_DQ:  begin fa = q;  fb = kl; freq.op = FOP_SUB; end
      STEP_DV:  begin fa = vr; fb = vl; freq.op = FOP_SUB; end
      STEP_DK:  begin fa = kr; fb = kl; freq.op = FOP_SUB; end
      STEP_MUL: begin fa = t1; fb = t2; freq.op = FOP_MUL; end
      STEP_DIV: begin fa = t1; fb = t3; freq.op = FOP_DIV; end
      default:  begin fa = t1; fb = vl; freq.op = FOP_ADD; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      eu <= 7'd2;
      out_valid <= 1'b0;
      have <= 1'b0;
      step <= STEP_DQ;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        eu <= entries_used;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      have <= (state == ST_SCAN) && issue;
      if (state == ST_LOADR) begin
        step <= STEP_DQ;
      end else if (state == ST_FPGO && skip_div) begin
        step <= STEP_ADD;
      end else if (state == ST_FPWAIT && fdone) begin
        step <= step_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_word <= res_word;
      status <= res_stat;
    end
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          q <= query_word;
          key_p <= (opcode == OP_E_FROM_P);
          n <= n_clamp;
          ia <= '0;
          found <= 1'b0;
          res_word <= '0;
          res_stat <= 1'b0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          ia <= ia + NW'(1);
        end
        ic <= ia;
        if (have) begin
          if (ic == '0) begin
            lo <= key_rd;
            hi <= key_rd;
          end else begin
            if (fp_lt(key_rd, lo)) lo <= key_rd;
            if (fp_lt(hi, key_rd)) hi <= key_rd;
          end
          if (!found && !fp_lt(key_rd, q)) begin
            found <= 1'b1;
            pos <= ic;
          end
        end
      end
      ST_RANGE: begin
        if (oor) begin
          res_stat <= 1'b1;
        end
        pos <= pos_clamp;
      end
      ST_RDR: begin
        kl <= key_rd;
        vl <= val_rd;
      end
      ST_LOADR: begin
        kr <= key_rd;
        vr <= val_rd;
      end
      ST_FPGO: begin
        if (skip_div) begin
          t1 <= qspec;
        end
      end
      ST_FPWAIT: begin
        if (fdone) begin
          case (step)
            STEP_DQ:  t1 <= fres;
            STEP_DV:  t2 <= fres;
            STEP_DK:  t3 <= fres;
            STEP_MUL: t1 <= fres;
            STEP_DIV: t1 <= fres;
            default:  res_word <= fres;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the table linear interpolator
// Loads binary64 tables, sends lookups in both directions, and compares
// every output beat with a predictor built on native binary64 arithmetic.
// Sender and receiver idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module tb_top;
  import tli_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [63:0] result_word;
    logic        status;
  } interp_result_t;

  class interp_scoreboard;
    logic [63:0] pres_col[64];
    logic [63:0] ener_col[64];
    logic [6:0] used_count;
    interp_result_t expected_q[$];
    int errors;

    function new();
      used_count = 7'd2;
      errors = 0;
    endfunction

    function void set_count(logic [6:0] v);
      used_count = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Division with the zero-span handling of the block.
    function real span_divide(real num, real den);
      logic [63:0] nb, db;
      if (den != 0.0) return num / den;
      if (num != num) return num;
      if (num == 0.0) return $bitstoreal(ZERO_DIV_NAN);
      nb = $realtobits(num);
      db = $realtobits(den);
      return $bitstoreal(((nb ^ db) & 64'h8000_0000_0000_0000) | 64'h7FF0_0000_0000_0000);
    endfunction

    function interp_result_t interpolate(bit by_pressure, logic [63:0] qw);
      interp_result_t r;
      int n, pos;
      real q, lo, hi, k, kl, kr, vl, vr, num;
      logic [63:0] keys[64];
      logic [63:0] vals[64];
      keys = by_pressure ? pres_col : ener_col;
      vals = by_pressure ? ener_col : pres_col;
      n = used_count;
      if (n < 2) n = 2;
      if (n > 64) n = 64;
      q = $bitstoreal(qw);
      lo = $bitstoreal(keys[0]);
      hi = lo;
      for (int i = 1; i < n; i++) begin
        k = $bitstoreal(keys[i]);
        if (k < lo) lo = k;
        if (hi < k) hi = k;
      end
      r.result_word = 64'd0;
      r.status = 1'b0;
      if (q < lo || q > hi) begin
        r.status = 1'b1;
        return r;
      end
      pos = n;
      for (int i = 0; i < n; i++) begin
        if (!(q > $bitstoreal(keys[i]))) begin
          pos = i;
          break;
        end
      end
      if (pos == 0) pos = 1;
      if (pos >= n) pos = n - 1;
      kl = $bitstoreal(keys[pos-1]);
      kr = $bitstoreal(keys[pos]);
      vl = $bitstoreal(vals[pos-1]);
      vr = $bitstoreal(vals[pos]);
      num = (q - kl) * (vr - vl);
      r.result_word = $realtobits(span_divide(num, kr - kl) + vl);
      return r;
    endfunction

    function void note_input(logic [1:0] op, logic [5:0] idx, logic [63:0] p,
                             logic [63:0] e, logic [63:0] q);
      interp_result_t r;
      r.result_word = 64'd0;
      r.status = 1'b0;
      case (op)
        OP_WRITE: begin
          pres_col[idx] = p;
          ener_col[idx] = e;
        end
        OP_E_FROM_P: r = interpolate(1'b1, q);
        OP_P_FROM_E: r = interpolate(1'b0, q);
        default: ;
      endcase
      expected_q = {expected_q, r};
    endfunction

    function void check_result(logic [63:0] res, logic st);
      interp_result_t x;
      if (expected_q.size() == 0) begin
        $error("unexpected output beat: result_word %h status %0d", res, st);
        errors++;
        return;
      end
      x = expected_q.pop_front();
      if (res !== x.result_word) begin
        $error("result_word: expected %h, actual %h", x.result_word, res);
        errors++;
      end
      if (st !== x.status) begin
        $error("status: expected %0d, actual %0d", x.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = OP_WRITE;
  logic [5:0] entry_index = '0;
  logic [63:0] pressure_word = '0;
  logic [63:0] energy_word = '0;
  logic [63:0] query_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] result_word;
  logic status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] entries_used = 7'd2;

  interp_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  logic [63:0] stim_p[64];
  logic [63:0] stim_e[64];

  table_linear_interpolator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .entry_index(entry_index),
    .pressure_word(pressure_word), .energy_word(energy_word), .query_word(query_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_word(result_word), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .entries_used(entries_used)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(0, 99) < rx_idle_pct);
  end

  // Every beat is noted here, on pre-edge values.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_count(entries_used);
      if (in_valid && !in_stall)
        sb.note_input(opcode, entry_index, pressure_word, energy_word, query_word);
      if (out_valid && !out_stall) sb.check_result(result_word, status);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [63:0] raw_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(logic [1:0] op, logic [5:0] idx, logic [63:0] p,
                           logic [63:0] e, logic [63:0] q);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    entry_index <= idx;
    pressure_word <= p;
    energy_word <= e;
    query_word <= q;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic write_entry(int idx, real p, real e);
    stim_p[idx] = $realtobits(p);
    stim_e[idx] = $realtobits(e);
    send_item(OP_WRITE, 6'(idx), stim_p[idx], stim_e[idx], raw_word());
  endtask

  task automatic write_raw(int idx, logic [63:0] p, logic [63:0] e);
    stim_p[idx] = p;
    stim_e[idx] = e;
    send_item(OP_WRITE, 6'(idx), p, e, raw_word());
  endtask

  task automatic lookup(logic [1:0] op, logic [63:0] q);
    send_item(op, 6'($urandom), raw_word(), raw_word(), q);
  endtask

  task automatic wait_drained(int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_entries(logic [6:0] v);
    wait_drained(8);
    cfg_valid <= 1'b1;
    entries_used <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_table(int n);
    int style;
    real kp, ke, scale, pick;
    style = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    scale = (pick < 5) ? 1.0 : (pick < 7) ? 1.0e-3 : (pick < 9) ? 1.0e6 : 1.0e-310;
    kp = ($itor($urandom_range(0, 2000)) - 1000.0) * scale;
    ke = ($itor($urandom_range(0, 2000)) - 1000.0) * scale;
    for (int i = 0; i < n; i++) begin
      if (style < 85) begin
        // Non-decreasing columns, energy drawn at random in some styles; duplicates give zero-span segments.
        if (!(style >= 75 && (i % 2) == 1)) begin
          kp = kp + $itor($urandom_range(1, 1000)) * scale * (1.0 + $urandom / 4294967296.0);
          ke = ke + $itor($urandom_range(1, 1000)) * scale * (1.0 + $urandom / 4294967296.0);
        end
        if (style >= 60 && style < 75)
          ke = ($itor($urandom_range(0, 2000)) - 1000.0) * scale;
        write_entry(i, kp, ke);
      end else if (style < 95) begin
        write_entry(i, $itor($urandom_range(0, 20)) - 10.0, $itor($urandom_range(0, 20)) - 10.0);
      end else begin
        write_raw(i, raw_word(), raw_word());
      end
    end
  endtask

  function automatic logic [63:0] pick_query(bit by_p, int n);
    logic [63:0] keys[64];
    real lo, hi, k, a, b;
    int r, i, j;
    keys = by_p ? stim_p : stim_e;
    lo = $bitstoreal(keys[0]);
    hi = lo;
    for (i = 1; i < n; i++) begin
      k = $bitstoreal(keys[i]);
      if (k < lo) lo = k;
      if (hi < k) hi = k;
    end
    r = $urandom_range(0, 99);
    i = $urandom_range(0, n - 1);
    j = $urandom_range(0, n - 1);
    a = $bitstoreal(keys[i]);
    b = $bitstoreal(keys[j]);
    if (r < 15) return keys[i];
    if (r < 25) return keys[0];
    if (r < 65) return $realtobits(a + ($urandom / 4294967296.0) * (b - a));
    if (r < 75) return $realtobits(lo - $itor($urandom_range(1, 100)) * (hi - lo + 1.0) / 64.0);
    if (r < 85) return $realtobits(hi + $itor($urandom_range(1, 100)) * (hi - lo + 1.0) / 64.0);
    if (r < 93) return raw_word();
    case ($urandom_range(0, 5))
      0: return 64'h7FF8_0000_0000_0001;
      1: return 64'hFFF0_0000_0000_0123;
      2: return 64'h7FF0_0000_0000_0000;
      3: return 64'hFFF0_0000_0000_0000;
      4: return 64'h0000_0000_0000_0000;
      default: return 64'h8000_0000_0000_0000;
    endcase
  endfunction

  task automatic run_phase(int target);
    int code, eff, nq, r;
    int stop_at;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      code = (r < 70) ? $urandom_range(2, 8) : (r < 80) ? $urandom_range(9, 63) :
             (r < 88) ? 64 : (r < 94) ? $urandom_range(0, 1) : $urandom_range(65, 127);
      eff = (code < 2) ? 2 : (code > 64) ? 64 : code;
      set_entries(7'(code));
      load_table(eff);
      nq = $urandom_range(10, 25);
      for (int i = 0; i < nq; i++) begin
        r = $urandom_range(0, 99);
        if (r < 45) lookup(OP_E_FROM_P, pick_query(1'b1, eff));
        else if (r < 90) lookup(OP_P_FROM_E, pick_query(1'b0, eff));
        else if (r < 95) send_item(OP_UNUSED, 6'($urandom), raw_word(), raw_word(), raw_word());
        else if (eff < 64) write_raw($urandom_range(eff, 63), raw_word(), raw_word());
        else write_raw($urandom_range(0, 63), raw_word(), raw_word());
        if ($urandom_range(0, 99) < 3) wait_drained(0);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the reset entry count of two.
    write_entry(0, 1.0, 10.0);
    write_entry(1, 3.0, 30.0);
    lookup(OP_E_FROM_P, $realtobits(1.0));
    lookup(OP_E_FROM_P, $realtobits(3.0));
    lookup(OP_E_FROM_P, $realtobits(2.0));
    lookup(OP_E_FROM_P, $realtobits(0.5));
    lookup(OP_E_FROM_P, $realtobits(3.5));
    lookup(OP_E_FROM_P, 64'h7FF8_0000_0000_0000);
    lookup(OP_P_FROM_E, $realtobits(10.0));
    lookup(OP_P_FROM_E, $realtobits(20.0));
    lookup(OP_P_FROM_E, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_UNUSED, 6'h3F, '1, '1, '1);
    send_item(OP_UNUSED, 6'h00, '0, '0, '0);
    write_raw(63, '1, '1);
    // Equal keys make a zero-span segment.
    write_entry(0, 2.0, 5.0);
    write_entry(1, 2.0, 7.0);
    lookup(OP_E_FROM_P, $realtobits(2.0));
    write_raw(0, 64'h0000_0000_0000_0000, $realtobits(1.0));
    write_raw(1, 64'h8000_0000_0000_0000, $realtobits(4.0));
    lookup(OP_E_FROM_P, 64'h0000_0000_0000_0000);
    lookup(OP_E_FROM_P, 64'h8000_0000_0000_0000);
    lookup(OP_P_FROM_E, $realtobits(2.5));

    // Every entry gets written before any lookup can reach it.
    set_entries(7'd64);
    load_table(64);

    tx_idle_pct = 31;
    rx_idle_pct = 50;
    run_phase(380);
    wait_drained(8);
    tx_idle_pct = 50;
    rx_idle_pct = 31;
    run_phase(380);
    wait_drained(8);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(380);
    set_entries(7'd127);
    set_entries(7'd2);

    wait_drained(50);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
